FILE: rtl/core/a8exe_pkg.sv
`default_nettype none

package a8exe_pkg;

    // Default data memory depth in 32-bit words.
    localparam int MEM_WORDS_DEF = 1024;

    // Width of the packed result word on the master side.
    localparam int OUT_W = 144;

    // Instruction classes produced by the front end.
    typedef enum logic [4:0] {
        OP_UNK,
        OP_B,
        OP_CBZ,
        OP_CBNZ,
        OP_BCOND,
        OP_MOVZ,
        OP_HLT,
        OP_ADDI,
        OP_SUBI,
        OP_UBFM,
        OP_ADD,
        OP_SUB,
        OP_AND,
        OP_ORR,
        OP_EOR,
        OP_MUL,
        OP_BR,
        OP_LDUR,
        OP_STUR
    } op_t;

    // One decoded instruction as it sits in the queue.
    typedef struct packed {
        op_t         op;
        logic        setf;
        logic [2:0]  nbm1;
        logic [31:0] instr;
    } entry_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_out_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_MOD,
        ST_MRD,
        ST_MWR
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/a8exe_ram.sv
`default_nettype none

module a8exe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/a8exe_front.sv
`default_nettype none

module a8exe_front (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [31:0]            s_tdata,   // instruction[31:0]
    input  wire logic                   clearing,
    output a8exe_pkg::queue_out_t       q_out,
    input  wire logic                   q_pop
);

    import a8exe_pkg::*;

    localparam logic [5:0]  OPC_B     = 6'h05;
    localparam logic [7:0]  OPC_CBZ   = 8'hB4;
    localparam logic [7:0]  OPC_CBNZ  = 8'hB5;
    localparam logic [7:0]  OPC_BCOND = 8'h54;
    localparam logic [10:0] OPC_MOVZ  = 11'h694;
    localparam logic [10:0] OPC_HLT   = 11'h6A2;
    localparam logic [9:0]  OPC_ADDI  = 10'h244;
    localparam logic [9:0]  OPC_ADDIS = 10'h2C4;
    localparam logic [9:0]  OPC_SUBI  = 10'h344;
    localparam logic [9:0]  OPC_SUBIS = 10'h3C4;
    localparam logic [9:0]  OPC_UBFM  = 10'h34D;
    localparam logic [10:0] OPC_ADD   = 11'h458;
    localparam logic [10:0] OPC_ADDS  = 11'h558;
    localparam logic [10:0] OPC_SUB   = 11'h658;
    localparam logic [10:0] OPC_SUBS  = 11'h758;
    localparam logic [10:0] OPC_AND   = 11'h450;
    localparam logic [10:0] OPC_ANDS  = 11'h750;
    localparam logic [10:0] OPC_ORR   = 11'h550;
    localparam logic [10:0] OPC_EOR   = 11'h650;
    localparam logic [10:0] OPC_MUL   = 11'h4D8;
    localparam logic [10:0] OPC_BR    = 11'h6B0;
    localparam logic [10:0] OPC_LDX   = 11'h7C2;
    localparam logic [10:0] OPC_LDW   = 11'h5C2;
    localparam logic [10:0] OPC_LDH   = 11'h3C2;
    localparam logic [10:0] OPC_LDB   = 11'h1C2;
    localparam logic [10:0] OPC_STX   = 11'h7C0;
    localparam logic [10:0] OPC_STW   = 11'h5C0;
    localparam logic [10:0] OPC_STH   = 11'h3C0;
    localparam logic [10:0] OPC_STB   = 11'h1C0;

    entry_t      q_mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    entry_t      dec;
    logic        push;
    logic [10:0] op11;
    logic [9:0]  op10;
    logic [7:0]  op8;

    assign op11 = s_tdata[31:21];
    assign op10 = s_tdata[31:22];
    assign op8  = s_tdata[31:24];

    // Classify the incoming word in the same priority as the architecture.
    always_comb begin
        dec.op    = OP_UNK;
        dec.setf  = 1'b0;
        dec.nbm1  = 3'd0;
        dec.instr = s_tdata;
        if (s_tdata[31:26] == OPC_B) begin
            dec.op = OP_B;
        end else if (op8 == OPC_CBZ) begin
            dec.op = OP_CBZ;
        end else if (op8 == OPC_CBNZ) begin
            dec.op = OP_CBNZ;
        end else if (op8 == OPC_BCOND) begin
            dec.op = OP_BCOND;
        end else if (op11 == OPC_MOVZ) begin
            dec.op = OP_MOVZ;
        end else if (op11 == OPC_HLT) begin
            dec.op = OP_HLT;
        end else if (op10 == OPC_ADDI || op10 == OPC_ADDIS) begin
            dec.op   = OP_ADDI;
            dec.setf = (op10 == OPC_ADDIS);
        end else if (op10 == OPC_SUBI || op10 == OPC_SUBIS) begin
            dec.op   = OP_SUBI;
            dec.setf = (op10 == OPC_SUBIS);
        end else if (op10 == OPC_UBFM) begin
            dec.op = OP_UBFM;
        end else begin
            case (op11)
                OPC_ADD:  dec.op = OP_ADD;
                OPC_ADDS: begin
                    dec.op   = OP_ADD;
                    dec.setf = 1'b1;
                end
                OPC_SUB:  dec.op = OP_SUB;
                OPC_SUBS: begin
                    dec.op   = OP_SUB;
                    dec.setf = 1'b1;
                end
                OPC_AND:  dec.op = OP_AND;
                OPC_ANDS: begin
                    dec.op   = OP_AND;
                    dec.setf = 1'b1;
                end
                OPC_ORR:  dec.op = OP_ORR;
                OPC_EOR:  dec.op = OP_EOR;
                OPC_MUL:  dec.op = OP_MUL;
                OPC_BR:   dec.op = OP_BR;
                OPC_LDX: begin
                    dec.op   = OP_LDUR;
                    dec.nbm1 = 3'd7;
                end
                OPC_LDW: begin
                    dec.op   = OP_LDUR;
                    dec.nbm1 = 3'd3;
                end
                OPC_LDH: begin
                    dec.op   = OP_LDUR;
                    dec.nbm1 = 3'd1;
                end
                OPC_LDB:  dec.op = OP_LDUR;
                OPC_STX: begin
                    dec.op   = OP_STUR;
                    dec.nbm1 = 3'd7;
                end
                OPC_STW: begin
                    dec.op   = OP_STUR;
                    dec.nbm1 = 3'd3;
                end
                OPC_STH: begin
                    dec.op   = OP_STUR;
                    dec.nbm1 = 3'd1;
                end
                OPC_STB:  dec.op = OP_STUR;
                default:  dec.op = OP_UNK;
            endcase
        end
    end

    // Two-entry queue toward the back end.
    assign s_tready    = (count_reg != 2'd2) && !clearing;
    assign push        = s_tvalid && s_tready;
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.entry = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/a8exe_back.sv
`default_nettype none

module a8exe_back #(
    parameter int MEM_WORDS = a8exe_pkg::MEM_WORDS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire a8exe_pkg::queue_out_t          q_in,
    output logic                                q_pop,
    output logic                                clearing,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [a8exe_pkg::OUT_W-1:0]         m_tdata
);

    import a8exe_pkg::*;

    localparam int BYTES = 4 * MEM_WORDS;
    localparam int BAW   = $clog2(BYTES);
    localparam int MAW   = BAW - 2;
    localparam bit POW2  = ((BYTES & (BYTES - 1)) == 0);
    localparam logic [BAW-1:0] LAST_B  = BAW'(BYTES - 1);
    localparam logic [MAW-1:0] LAST_W  = MAW'(MEM_WORDS - 1);
    localparam logic [31:0]    RECIP   = 32'((64'd1 << 32) / MEM_WORDS);
    localparam logic [31:0]    WORDS_C = 32'(MEM_WORDS);
    localparam logic [4:0]     XZR     = 5'd31;
    localparam logic [63:0]    ONES    = {64{1'b1}};

    localparam logic [3:0] CC_EQ = 4'h0;
    localparam logic [3:0] CC_NE = 4'h1;
    localparam logic [3:0] CC_HS = 4'h2;
    localparam logic [3:0] CC_LO = 4'h3;
    localparam logic [3:0] CC_MI = 4'h4;
    localparam logic [3:0] CC_PL = 4'h5;
    localparam logic [3:0] CC_VS = 4'h6;
    localparam logic [3:0] CC_VC = 4'h7;
    localparam logic [3:0] CC_HI = 4'h8;
    localparam logic [3:0] CC_LS = 4'h9;
    localparam logic [3:0] CC_GE = 4'hA;
    localparam logic [3:0] CC_LT = 4'hB;
    localparam logic [3:0] CC_GT = 4'hC;
    localparam logic [3:0] CC_LE = 4'hD;

    // Condition test; carry and overflow always read as clear.
    function automatic logic cond_ok(input logic [3:0] c, input logic z, input logic n);
        logic r;
        case (c)
            CC_EQ:   r = z;
            CC_NE:   r = !z;
            CC_HS:   r = 1'b0;
            CC_LO:   r = 1'b1;
            CC_MI:   r = n;
            CC_PL:   r = !n;
            CC_VS:   r = 1'b0;
            CC_VC:   r = 1'b1;
            CC_HI:   r = 1'b0;
            CC_LS:   r = 1'b1;
            CC_GE:   r = !n;
            CC_LT:   r = n;
            CC_GT:   r = !z && !n;
            CC_LE:   r = z || n;
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    state_t         state_reg, state_next;
    logic [MAW-1:0] clr_cnt_reg, clr_cnt_next;
    entry_t         ent_reg, ent_next;
    logic [4:0]     bidx_reg, bidx_next;
    logic [63:0]    opa_reg, opa_next;
    logic [63:0]    opb_reg, opb_next;
    logic [63:0]    addr_reg, addr_next;
    logic [MAW-1:0] rem_reg, rem_next;
    logic [5:0]     bit_reg, bit_next;
    logic [BAW-1:0] byte_reg, byte_next;
    logic [2:0]     cnt_reg, cnt_next;
    logic [63:0]    acc_reg, acc_next;
    logic [1:0]     mcnt_reg, mcnt_next;
    logic [63:0]    p0_reg, p0_next;
    logic [31:0]    c_reg, c_next;
    logic [63:0]    pc_reg, pc_next;
    logic           z_reg, z_next;
    logic           n_reg, n_next;
    logic           halt_reg, halt_next;
    logic [31:0]    rf_valid_reg, rf_valid_next;
    logic           m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_data_reg, m_data_next;

    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [63:0] rf_wdata;
    logic [4:0]  rfb_raddr;
    logic [63:0] rfa_rdata, rfb_rdata;
    logic        mem_we, mem_re;
    logic [MAW-1:0] mem_waddr, mem_raddr;
    logic [31:0] mem_wdata, mem_rdata;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic [31:0] ins;
    logic [4:0]  rn_idx, rd_idx;
    logic [63:0] rn_v, rb_v;
    logic [63:0] sext9, off26, off19;
    logic [5:0]  immr, imms, dlen;
    logic [15:0] mod_digit;
    logic [31:0] mod_v, mod_d;
    logic [7:0]  mbyte;
    logic [31:0] lane_mask, lane_data;

    logic        fin, f_held, f_wr, f_br, f_mw, f_unk, f_setf, f_halt, wr_eff;
    logic [63:0] f_val, f_npc, out_val;
    logic [4:0]  out_rd;
    logic        z_out, n_out;

    // Register file: two read copies written together.
    a8exe_ram #(.WIDTH(64), .DEPTH(32)) u_rf_a (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (q_pop),
        .raddr (q_in.entry.instr[9:5]),
        .rdata (rfa_rdata)
    );

    a8exe_ram #(.WIDTH(64), .DEPTH(32)) u_rf_b (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (q_pop),
        .raddr (rfb_raddr),
        .rdata (rfb_rdata)
    );

    // Data memory, one word per entry.
    a8exe_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The one shared 32 by 32 multiplier.
    assign mul_p = mul_a * mul_b;

    assign clearing = (state_reg == ST_CLEAR);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign q_pop    = (state_reg == ST_IDLE) && q_in.valid && (!m_valid_reg || m_tready);

    // Second read port serves Rt for compare branches and stores, else Rm.
    assign rfb_raddr = (q_in.entry.op == OP_CBZ || q_in.entry.op == OP_CBNZ ||
                        q_in.entry.op == OP_STUR) ? q_in.entry.instr[4:0]
                                                  : q_in.entry.instr[20:16];

    // Operand fields of the instruction in flight.
    assign ins    = ent_reg.instr;
    assign rn_idx = ins[9:5];
    assign rd_idx = ins[4:0];
    assign rn_v   = (rn_idx != XZR && rf_valid_reg[rn_idx]) ? rfa_rdata : 64'd0;
    assign rb_v   = (bidx_reg != XZR && rf_valid_reg[bidx_reg]) ? rfb_rdata : 64'd0;
    assign sext9  = {{55{ins[20]}}, ins[20:12]};
    assign off26  = {{36{ins[25]}}, ins[25:0], 2'b00};
    assign off19  = {{43{ins[23]}}, ins[23:5], 2'b00};
    assign immr   = ins[21:16];
    assign imms   = ins[15:10];
    assign dlen   = imms - immr;

    // Word address digit under reduction and the partial remainder it extends.
    assign mod_digit = 16'(addr_reg >> ({bit_reg[1:0], 4'b0000} + 6'd2));
    assign mod_v     = {16'(rem_reg), mod_digit};
    assign mod_d     = mod_v - p0_reg[31:0];

    // Byte lane of the word read back from data memory.
    assign mbyte     = 8'(mem_rdata >> {byte_reg[1:0], 3'b000});
    assign lane_mask = 32'hFF << {byte_reg[1:0], 3'b000};
    assign lane_data = {24'd0, 8'(opb_reg >> {cnt_reg, 3'b000})} << {byte_reg[1:0], 3'b000};

    // Sequencer: next state, datapath and retirement.
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        ent_next      = ent_reg;
        bidx_next     = bidx_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        addr_next     = addr_reg;
        rem_next      = rem_reg;
        bit_next      = bit_reg;
        byte_next     = byte_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        mcnt_next     = mcnt_reg;
        p0_next       = p0_reg;
        c_next        = c_reg;
        mul_a         = opa_reg[31:0];
        mul_b         = opb_reg[31:0];
        mem_we        = 1'b0;
        mem_waddr     = byte_reg[BAW-1:2];
        mem_wdata     = (mem_rdata & ~lane_mask) | lane_data;
        mem_re        = 1'b0;
        mem_raddr     = byte_reg[BAW-1:2];
        fin           = 1'b0;
        f_held        = 1'b0;
        f_wr          = 1'b0;
        f_br          = 1'b0;
        f_mw          = 1'b0;
        f_unk         = 1'b0;
        f_setf        = 1'b0;
        f_halt        = halt_reg;
        f_val         = 64'd0;
        f_npc         = pc_reg + 64'd4;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = 32'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_W) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_pop) begin
                    ent_next   = q_in.entry;
                    bidx_next  = rfb_raddr;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                opa_next  = rn_v;
                opb_next  = rb_v;
                state_next = ST_IDLE;
                if (halt_reg) begin
                    fin    = 1'b1;
                    f_held = 1'b1;
                end else begin
                    case (ent_reg.op)
                        OP_B: begin
                            fin = 1'b1; f_br = 1'b1; f_npc = pc_reg + off26;
                        end
                        OP_CBZ, OP_CBNZ, OP_BCOND: begin
                            fin = 1'b1;
                            if (ent_reg.op == OP_CBZ) begin
                                f_br = (rb_v == 64'd0);
                            end else if (ent_reg.op == OP_CBNZ) begin
                                f_br = (rb_v != 64'd0);
                            end else begin
                                f_br = cond_ok(ins[3:0], z_reg, n_reg);
                            end
                            if (f_br) begin
                                f_npc = pc_reg + off19;
                            end
                        end
                        OP_MOVZ: begin
                            fin = 1'b1; f_wr = 1'b1; f_val = {48'd0, ins[20:5]};
                        end
                        OP_HLT: begin
                            fin = 1'b1; f_halt = 1'b1;
                        end
                        OP_ADDI: begin
                            fin = 1'b1; f_wr = 1'b1; f_setf = ent_reg.setf;
                            f_val = rn_v + {52'd0, ins[21:10]};
                        end
                        OP_SUBI: begin
                            fin = 1'b1; f_wr = 1'b1; f_setf = ent_reg.setf;
                            f_val = rn_v - {52'd0, ins[21:10]};
                        end
                        OP_UBFM: begin
                            fin = 1'b1; f_wr = 1'b1;
                            if (imms >= immr) begin
                                f_val = (rn_v >> immr) & (ONES >> (6'd63 - dlen));
                            end else begin
                                f_val = (rn_v & (ONES >> (6'd63 - imms)))
                                        << (7'd64 - {1'b0, immr});
                            end
                        end
                        OP_ADD: begin
                            fin = 1'b1; f_wr = 1'b1; f_setf = ent_reg.setf;
                            f_val = rn_v + rb_v;
                        end
                        OP_SUB: begin
                            fin = 1'b1; f_wr = 1'b1; f_setf = ent_reg.setf;
                            f_val = rn_v - rb_v;
                        end
                        OP_AND: begin
                            fin = 1'b1; f_wr = 1'b1; f_setf = ent_reg.setf;
                            f_val = rn_v & rb_v;
                        end
                        OP_ORR: begin
                            fin = 1'b1; f_wr = 1'b1; f_val = rn_v | rb_v;
                        end
                        OP_EOR: begin
                            fin = 1'b1; f_wr = 1'b1; f_val = rn_v ^ rb_v;
                        end
                        OP_MUL: begin
                            mcnt_next  = 2'd0;
                            state_next = ST_MUL;
                        end
                        OP_BR: begin
                            fin = 1'b1; f_br = 1'b1; f_npc = rn_v;
                        end
                        OP_LDUR, OP_STUR: begin
                            addr_next = rn_v + sext9;
                            cnt_next  = 3'd0;
                            acc_next  = 64'd0;
                            if (POW2) begin
                                byte_next  = addr_next[BAW-1:0];
                                state_next = ST_MRD;
                            end else begin
                                rem_next   = '0;
                                bit_next   = 6'd3;
                                mcnt_next  = 2'd0;
                                state_next = ST_MOD;
                            end
                        end
                        default: begin
                            fin = 1'b1; f_unk = 1'b1;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                // Low 64 bits from three partial products.
                mcnt_next = mcnt_reg + 2'd1;
                case (mcnt_reg)
                    2'd0: p0_next = mul_p;
                    2'd1: begin
                        mul_b  = opb_reg[63:32];
                        c_next = mul_p[31:0];
                    end
                    2'd2: begin
                        mul_a  = opa_reg[63:32];
                        c_next = c_reg + mul_p[31:0];
                    end
                    default: begin
                        fin = 1'b1; f_wr = 1'b1;
                        f_val = p0_reg + {c_reg, 32'd0};
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MOD: begin
                // Word address modulo the depth, one 16-bit digit at a time from
                // the top: reciprocal quotient estimate, back-multiply, subtract and fix.
                mcnt_next = mcnt_reg + 2'd1;
                case (mcnt_reg)
                    2'd0: begin
                        mul_a  = mod_v;
                        mul_b  = RECIP;
                        c_next = mul_p[63:32];
                    end
                    2'd1: begin
                        mul_a   = c_reg;
                        mul_b   = WORDS_C;
                        p0_next = mul_p;
                    end
                    default: begin
                        mcnt_next = 2'd0;
                        rem_next  = (mod_d >= WORDS_C) ? MAW'(mod_d - WORDS_C) : MAW'(mod_d);
                        bit_next  = bit_reg - 6'd1;
                        if (bit_reg == 6'd0) begin
                            byte_next  = {rem_next, addr_reg[1:0]};
                            state_next = ST_MRD;
                        end
                    end
                endcase
            end
            ST_MRD: begin
                mem_re     = 1'b1;
                state_next = ST_MWR;
            end
            ST_MWR: begin
                // One byte per visit; stores merge it into the word.
                acc_next = acc_reg | ({56'd0, mbyte} << {cnt_reg, 3'b000});
                if (ent_reg.op == OP_STUR) begin
                    mem_we = 1'b1;
                end
                cnt_next  = cnt_reg + 3'd1;
                byte_next = (byte_reg == LAST_B) ? '0 : byte_reg + 1'b1;
                state_next = ST_MRD;
                if (cnt_reg == ent_reg.nbm1) begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                    if (ent_reg.op == OP_STUR) begin
                        f_mw = 1'b1;
                    end else begin
                        f_wr  = 1'b1;
                        f_val = acc_next;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Retirement: architectural state and the result word.
    always_comb begin
        pc_next       = pc_reg;
        z_next        = z_reg;
        n_next        = n_reg;
        halt_next     = halt_reg;
        rf_valid_next = rf_valid_reg;
        wr_eff        = f_wr && (rd_idx != XZR);
        out_val       = wr_eff ? f_val : 64'd0;
        out_rd        = wr_eff ? rd_idx : 5'd0;
        z_out         = f_setf ? (f_val == 64'd0) : z_reg;
        n_out         = f_setf ? f_val[63] : n_reg;
        rf_we         = fin && !f_held && wr_eff;
        rf_waddr      = rd_idx;
        rf_wdata      = f_val;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        if (fin) begin
            m_valid_next = 1'b1;
            if (f_held) begin
                m_data_next = {4'd0, 1'b0, 1'b1, n_reg, z_reg, 1'b0, 1'b0,
                               64'd0, 5'd0, 1'b0, pc_reg};
            end else begin
                pc_next   = f_npc;
                z_next    = z_out;
                n_next    = n_out;
                halt_next = f_halt;
                if (wr_eff) begin
                    rf_valid_next[rd_idx] = 1'b1;
                end
                m_data_next = {4'd0, f_unk, f_halt, n_out, z_out, f_br, f_mw,
                               out_val, out_rd, wr_eff, f_npc};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            pc_reg       <= 64'd0;
            z_reg        <= 1'b0;
            n_reg        <= 1'b0;
            halt_reg     <= 1'b0;
            rf_valid_reg <= 32'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            pc_reg       <= pc_next;
            z_reg        <= z_next;
            n_reg        <= n_next;
            halt_reg     <= halt_next;
            rf_valid_reg <= rf_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        ent_reg    <= ent_next;
        bidx_reg   <= bidx_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        addr_reg   <= addr_next;
        rem_reg    <= rem_next;
        bit_reg    <= bit_next;
        byte_reg   <= byte_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcnt_reg   <= mcnt_next;
        p0_reg     <= p0_next;
        c_reg      <= c_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    // Once halted the program counter never moves.
    a_halt_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> $stable(pc_reg)) else $error("pc moved after halt");

    // The zero register is never written.
    a_no_xzr: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_we |-> (rf_waddr != XZR)) else $error("write to register 31");

    // Nothing retires during the memory clearing pass.
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!fin && !q_pop)) else $error("retire while clearing");

    // Outside the clearing pass only stores write data memory.
    a_store_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg != ST_CLEAR) |-> (ent_reg.op == OP_STUR))
        else $error("stray memory write");

    // A retirement never overwrites a result still waiting.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin && m_valid_reg) |-> m_tready) else $error("result overwritten");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/armv8_subset_instruction_executor_core.sv
`default_nettype none

// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tdata[31:0] instruction
// m_        out  m_tvalid/m_tready   m_tdata[143:0] next_pc .. unknown_op
//
// Most instructions are a register file read, then execute and write back.
// MUL shares one 32x32 multiplier over three partial products.
// Loads and stores move one byte at a time through the single data memory, and first
// reduce the address modulo the memory size when 4*MEM_WORDS is not a power of two.
// After reset a clearing pass zeroes data memory; s_tready is low during it.
// A two-entry queue lets the front accept while the back waits on m_tready.
module armv8_subset_instruction_executor_core #(
    parameter int MEM_WORDS = a8exe_pkg::MEM_WORDS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // instruction[31:0]
    input  wire logic [31:0]                 s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // next_pc[63:0], reg_write[64], dest_reg[69:65], dest_value[133:70],
    // mem_write[134], branch_taken[135], flag_zero[136], flag_negative[137],
    // halted[138], unknown_op[139], zero fill [143:140]
    output logic [a8exe_pkg::OUT_W-1:0]      m_tdata
);

    import a8exe_pkg::*;

    queue_out_t q_head;
    logic       q_pop;
    logic       clearing;

    // Front end: decode and queue.
    a8exe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .clearing (clearing),
        .q_out    (q_head),
        .q_pop    (q_pop)
    );

    // Back end: execute, memory and retirement.
    a8exe_back #(.MEM_WORDS(MEM_WORDS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_in     (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: verif/tb_armv8_subset_instruction_executor_core.sv
`timescale 1ns / 1ps

module tb_armv8_subset_instruction_executor_core;
    import a8exe_pkg::*;

    // Opcode fields as they sit in the instruction word.
    localparam logic [10:0] OPC_ADD   = 11'h458;
    localparam logic [10:0] OPC_ADDS  = 11'h558;
    localparam logic [10:0] OPC_SUB   = 11'h658;
    localparam logic [10:0] OPC_SUBS  = 11'h758;
    localparam logic [10:0] OPC_AND   = 11'h450;
    localparam logic [10:0] OPC_ANDS  = 11'h750;
    localparam logic [10:0] OPC_ORR   = 11'h550;
    localparam logic [10:0] OPC_EOR   = 11'h650;
    localparam logic [10:0] OPC_MUL   = 11'h4D8;
    localparam logic [10:0] OPC_BR    = 11'h6B0;
    localparam logic [10:0] OPC_LDURX = 11'h7C2;
    localparam logic [10:0] OPC_LDURW = 11'h5C2;
    localparam logic [10:0] OPC_LDURH = 11'h3C2;
    localparam logic [10:0] OPC_LDURB = 11'h1C2;
    localparam logic [10:0] OPC_STURX = 11'h7C0;
    localparam logic [10:0] OPC_STURW = 11'h5C0;
    localparam logic [10:0] OPC_STURH = 11'h3C0;
    localparam logic [10:0] OPC_STURB = 11'h1C0;
    localparam logic [10:0] OPC_MOVZ  = 11'h694;
    localparam logic [10:0] OPC_HLT   = 11'h6A2;
    localparam logic [9:0]  OPC_ADDI  = 10'h244;
    localparam logic [9:0]  OPC_ADDIS = 10'h2C4;
    localparam logic [9:0]  OPC_SUBI  = 10'h344;
    localparam logic [9:0]  OPC_SUBIS = 10'h3C4;
    localparam logic [9:0]  OPC_UBFM  = 10'h34D;
    localparam logic [7:0]  OPC_CBZ   = 8'hB4;
    localparam logic [7:0]  OPC_CBNZ  = 8'hB5;
    localparam logic [7:0]  OPC_BCOND = 8'h54;
    localparam logic [5:0]  OPC_B     = 6'h05;

    // Condition codes.
    localparam logic [3:0] CC_EQ = 4'h0;
    localparam logic [3:0] CC_NE = 4'h1;
    localparam logic [3:0] CC_HS = 4'h2;
    localparam logic [3:0] CC_LO = 4'h3;
    localparam logic [3:0] CC_MI = 4'h4;
    localparam logic [3:0] CC_PL = 4'h5;
    localparam logic [3:0] CC_VS = 4'h6;
    localparam logic [3:0] CC_VC = 4'h7;
    localparam logic [3:0] CC_HI = 4'h8;
    localparam logic [3:0] CC_LS = 4'h9;
    localparam logic [3:0] CC_GE = 4'hA;
    localparam logic [3:0] CC_LT = 4'hB;
    localparam logic [3:0] CC_GT = 4'hC;
    localparam logic [3:0] CC_LE = 4'hD;

    localparam int XZR       = 31;
    localparam int MEM_BYTES = 4 * MEM_WORDS_DEF;
    localparam int N_RANDOM  = 1950;

    // Idle and stall percentages of the four phases.
    localparam int IDLE_PCT [4]  = '{0, 47, 0, 23};
    localparam int STALL_PCT [4] = '{0, 0, 47, 23};

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    // instruction[31:0]
    logic [31:0]   s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    // next_pc, reg_write, dest_reg, dest_value, mem_write, branch_taken,
    // flag_zero, flag_negative, halted, unknown_op, zero fill
    logic [OUT_W-1:0] m_tdata;

    armv8_subset_instruction_executor_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Architectural state mirrored by the predictor.
    logic [63:0] arch_x [0:30];
    logic [63:0] arch_pc;
    logic        arch_z;
    logic        arch_n;
    logic        arch_halt;
    logic [7:0]  arch_mem [0:MEM_BYTES-1];

    logic [31:0]      instr_words [$];
    logic [OUT_W-1:0] expected_words [$];
    int               total_words;
    int               taken_words;
    int               err_count;
    logic             took_last;

    always #1 aclk = ~aclk;

    function automatic logic [63:0] read_x(input logic [4:0] idx);
        return (idx == XZR) ? 64'd0 : arch_x[idx];
    endfunction

    function automatic logic [63:0] ones_below(input int w);
        return (w >= 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic cond_true(input logic [3:0] cc);
        case (cc)
            CC_EQ: return arch_z;
            CC_NE: return !arch_z;
            CC_HS, CC_VS, CC_HI: return 1'b0;
            CC_MI, CC_LT: return arch_n;
            CC_PL, CC_GE: return !arch_n;
            CC_GT: return !arch_z && !arch_n;
            CC_LE: return arch_z || arch_n;
            default: return 1'b1;
        endcase
    endfunction

    // Execute one instruction on the mirrored state and form the expected word.
    task automatic execute_instr(input logic [31:0] ins, output logic [OUT_W-1:0] res);
        logic [63:0] rn_v, rm_v, rt_v, npc, val, addr, imm;
        logic [4:0]  rd;
        logic        wr, mw, br, unk, setf, take;
        int          immr, imms, nbytes;
        logic [11:0] b;
        rd   = ins[4:0];
        rn_v = read_x(ins[9:5]);
        rm_v = read_x(ins[20:16]);
        rt_v = read_x(rd);
        npc  = arch_pc + 64'd4;
        val  = '0;
        wr = 0; mw = 0; br = 0; unk = 0; setf = 0;
        res  = '0;
        if (arch_halt) begin
            res[63:0] = arch_pc;
            res[136]  = arch_z;
            res[137]  = arch_n;
            res[138]  = 1'b1;
            return;
        end
        if (ins[31:26] == OPC_B) begin
            npc = arch_pc + {{36{ins[25]}}, ins[25:0], 2'b00};
            br  = 1;
        end else if (ins[31:24] == OPC_CBZ || ins[31:24] == OPC_CBNZ
                     || ins[31:24] == OPC_BCOND) begin
            if (ins[31:24] == OPC_CBZ) take = (rt_v == 0);
            else if (ins[31:24] == OPC_CBNZ) take = (rt_v != 0);
            else take = cond_true(ins[3:0]);
            if (take) begin
                npc = arch_pc + {{43{ins[23]}}, ins[23:5], 2'b00};
                br  = 1;
            end
        end else if (ins[31:21] == OPC_MOVZ) begin
            wr = 1; val = {48'd0, ins[20:5]};
        end else if (ins[31:21] == OPC_HLT) begin
            arch_halt = 1;
        end else if (ins[31:22] == OPC_ADDI || ins[31:22] == OPC_ADDIS
                     || ins[31:22] == OPC_SUBI || ins[31:22] == OPC_SUBIS) begin
            imm  = {52'd0, ins[21:10]};
            wr   = 1;
            val  = (ins[31:22] == OPC_ADDI || ins[31:22] == OPC_ADDIS) ? rn_v + imm
                                                                      : rn_v - imm;
            setf = (ins[31:22] == OPC_ADDIS || ins[31:22] == OPC_SUBIS);
        end else if (ins[31:22] == OPC_UBFM) begin
            immr = ins[21:16];
            imms = ins[15:10];
            wr   = 1;
            if (imms >= immr) val = (rn_v >> immr) & ones_below(imms - immr + 1);
            else val = (rn_v & ones_below(imms + 1)) << (64 - immr);
        end else begin
            addr = rn_v + {{55{ins[20]}}, ins[20:12]};
            case (ins[31:21])
                OPC_ADD:  begin wr = 1; val = rn_v + rm_v; end
                OPC_ADDS: begin wr = 1; val = rn_v + rm_v; setf = 1; end
                OPC_SUB:  begin wr = 1; val = rn_v - rm_v; end
                OPC_SUBS: begin wr = 1; val = rn_v - rm_v; setf = 1; end
                OPC_AND:  begin wr = 1; val = rn_v & rm_v; end
                OPC_ANDS: begin wr = 1; val = rn_v & rm_v; setf = 1; end
                OPC_ORR:  begin wr = 1; val = rn_v | rm_v; end
                OPC_EOR:  begin wr = 1; val = rn_v ^ rm_v; end
                OPC_MUL:  begin wr = 1; val = rn_v * rm_v; end
                OPC_BR:   begin npc = rn_v; br = 1; end
                OPC_LDURX, OPC_LDURW, OPC_LDURH, OPC_LDURB: begin
                    wr = 1;
                    nbytes = 1 << ins[31:30];
                    for (int i = nbytes - 1; i >= 0; i--) begin
                        b   = addr[11:0] + i[11:0];
                        val = (val << 8) | {56'd0, arch_mem[b]};
                    end
                end
                OPC_STURX, OPC_STURW, OPC_STURH, OPC_STURB: begin
                    mw = 1;
                    nbytes = 1 << ins[31:30];
                    for (int i = 0; i < nbytes; i++) begin
                        b = addr[11:0] + i[11:0];
                        arch_mem[b] = rt_v[8*i +: 8];
                    end
                end
                default: unk = 1;
            endcase
        end
        if (setf) begin
            arch_z = (val == 0);
            arch_n = val[63];
        end
        if (wr && rd != XZR) arch_x[rd] = val;
        else begin
            wr = 0; val = 0; rd = 0;
        end
        arch_pc = npc;
        res[63:0]   = npc;
        res[64]     = wr;
        res[69:65]  = rd;
        res[133:70] = val;
        res[134]    = mw;
        res[135]    = br;
        res[136]    = arch_z;
        res[137]    = arch_n;
        res[138]    = arch_halt;
        res[139]    = unk;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
            err_count++;
        end
    endtask

    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 9) == 0) return 5'(XZR);
        return 5'($urandom_range(0, 11));
    endfunction

    // Instruction of a random kind with random fields, or random noise.
    function automatic logic [31:0] random_instr();
        logic [10:0] rops [10] = '{OPC_ADD, OPC_ADDS, OPC_SUB, OPC_SUBS, OPC_AND,
                                   OPC_ANDS, OPC_ORR, OPC_EOR, OPC_MUL, OPC_BR};
        logic [10:0] mops [8]  = '{OPC_LDURX, OPC_LDURW, OPC_LDURH, OPC_LDURB,
                                   OPC_STURX, OPC_STURW, OPC_STURH, OPC_STURB};
        logic [9:0]  iops [4]  = '{OPC_ADDI, OPC_ADDIS, OPC_SUBI, OPC_SUBIS};
        logic [7:0]  cops [3]  = '{OPC_CBZ, OPC_CBNZ, OPC_BCOND};
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0, 1: w = {rops[$urandom_range(0, 9)], pick_reg(), w[15:10], pick_reg(),
                       pick_reg()};
            2:    w = {iops[$urandom_range(0, 3)], w[21:10], pick_reg(), pick_reg()};
            3:    w = {OPC_UBFM, w[21:10], pick_reg(), pick_reg()};
            4:    w = {OPC_MOVZ, w[20:5], pick_reg()};
            5, 6: w = {mops[$urandom_range(0, 7)], w[20:10], pick_reg(), pick_reg()};
            7:    w = {OPC_B, w[25:0]};
            8:    w = {cops[$urandom_range(0, 2)], w[23:5], pick_reg()};
            default: begin
                // Noise; a halt here would end the test early.
                while (w[31:21] == OPC_HLT) w = $urandom;
            end
        endcase
        return w;
    endfunction

    // Input side: hold a pending word until it is taken; output side: randomly stall m_tready.
    always @(negedge aclk) begin
        int ph;
        ph = (total_words == 0) ? 0 : (taken_words * 4) / total_words;
        if (ph > 3) ph = 3;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= STALL_PCT[ph]);
            if (s_tvalid && !took_last) begin
                s_tvalid <= 1'b1;
            end else if (instr_words.size() > 0 && $urandom_range(0, 99) >= IDLE_PCT[ph]) begin
                s_tvalid <= 1'b1;
                s_tdata  <= instr_words[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Predict on each accepted word and check each returned word.
    always @(posedge aclk) begin
        logic [OUT_W-1:0] exp_w;
        took_last <= 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            execute_instr(s_tdata, exp_w);
            expected_words.push_back(exp_w);
            void'(instr_words.pop_front());
            taken_words++;
            took_last <= 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, m_tdata);
                err_count++;
            end else begin
                exp_w = expected_words.pop_front();
                check_field("next_pc", exp_w[63:0], m_tdata[63:0]);
                check_field("reg_write", 64'(exp_w[64]), 64'(m_tdata[64]));
                check_field("dest_reg", 64'(exp_w[69:65]), 64'(m_tdata[69:65]));
                check_field("dest_value", exp_w[133:70], m_tdata[133:70]);
                check_field("mem_write", 64'(exp_w[134]), 64'(m_tdata[134]));
                check_field("branch_taken", 64'(exp_w[135]), 64'(m_tdata[135]));
                check_field("flag_zero", 64'(exp_w[136]), 64'(m_tdata[136]));
                check_field("flag_negative", 64'(exp_w[137]), 64'(m_tdata[137]));
                check_field("halted", 64'(exp_w[138]), 64'(m_tdata[138]));
                check_field("unknown_op", 64'(exp_w[139]), 64'(m_tdata[139]));
            end
        end
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aclk      = 0;
        aresetn   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        m_tready  = 0;
        took_last = 0;
        err_count = 0;
        taken_words = 0;
        arch_pc = '0; arch_z = 0; arch_n = 0; arch_halt = 0;
        foreach (arch_x[i]) arch_x[i] = '0;
        foreach (arch_mem[i]) arch_mem[i] = '0;

        // Directed: field extremes, flags, every width of load and store, branches.
        instr_words.push_back({OPC_MOVZ, 16'hFFFF, 5'd1});
        instr_words.push_back({OPC_MOVZ, 16'h0001, 5'd2});
        instr_words.push_back({OPC_SUBS, 5'd2, 6'h3F, 5'd2, 5'd3});
        instr_words.push_back({OPC_SUBS, 5'd2, 6'd0, 5'd31, 5'd4});
        instr_words.push_back({OPC_ADDS, 5'd1, 6'd0, 5'd1, 5'd31});
        instr_words.push_back({OPC_UBFM, 6'd1, 6'd0, 5'd1, 5'd5});
        instr_words.push_back({OPC_UBFM, 6'd63, 6'd63, 5'd4, 5'd6});
        instr_words.push_back({OPC_MUL, 5'd4, 6'h3F, 5'd4, 5'd7});
        instr_words.push_back({OPC_ADDI, 12'hFFF, 5'd1, 5'd8});
        instr_words.push_back({OPC_SUBIS, 12'hFFF, 5'd31, 5'd9});
        instr_words.push_back({OPC_ANDS, 5'd4, 6'd0, 5'd1, 5'd10});
        instr_words.push_back({OPC_ORR, 5'd4, 6'd0, 5'd1, 5'd11});
        instr_words.push_back({OPC_EOR, 5'd4, 6'd0, 5'd1, 5'd12});
        instr_words.push_back({OPC_STURX, 9'h100, 2'b11, 5'd31, 5'd4});
        instr_words.push_back({OPC_STURW, 9'h0FF, 2'b00, 5'd2, 5'd1});
        instr_words.push_back({OPC_STURH, 9'h003, 2'b00, 5'd31, 5'd5});
        instr_words.push_back({OPC_STURB, 9'h1FF, 2'b00, 5'd31, 5'd12});
        instr_words.push_back({OPC_LDURX, 9'h100, 2'b00, 5'd31, 5'd13});
        instr_words.push_back({OPC_LDURW, 9'h0FF, 2'b11, 5'd2, 5'd14});
        instr_words.push_back({OPC_LDURH, 9'h003, 2'b00, 5'd31, 5'd15});
        instr_words.push_back({OPC_LDURB, 9'h1FF, 2'b00, 5'd31, 5'd16});
        instr_words.push_back({OPC_CBZ, 19'h7FFFF, 5'd31});
        instr_words.push_back({OPC_CBNZ, 19'h40000, 5'd1});
        instr_words.push_back({OPC_BCOND, 19'h00010, 1'b1, CC_LE});
        instr_words.push_back({OPC_B, 26'h2000000});
        instr_words.push_back({OPC_BR, 5'd0, 6'd0, 5'd1, 5'd0});
        instr_words.push_back(32'h0000_0000);

        for (int i = 0; i < N_RANDOM; i++) instr_words.push_back(random_instr());

        // Halt closes the run; the words after it must change nothing.
        instr_words.push_back({OPC_HLT, 16'h0000, 5'd0});
        instr_words.push_back({OPC_MOVZ, 16'h1234, 5'd3});
        instr_words.push_back({OPC_B, 26'h0000010});
        total_words = instr_words.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        while (instr_words.size() > 0 || expected_words.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
